FILE: rtl/cll_pkg.sv
// Package with shared constants, action and status codes for the linked list engine.
package cll_pkg;
  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ActionWidth  = 3;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned CountWidth   = 5;

  localparam logic [ActionWidth-1:0] ActInsHead  = 3'd0;
  localparam logic [ActionWidth-1:0] ActInsTail  = 3'd1;
  localparam logic [ActionWidth-1:0] ActInsSort  = 3'd2;
  localparam logic [ActionWidth-1:0] ActDelFirst = 3'd3;
  localparam logic [ActionWidth-1:0] ActDelAll   = 3'd4;
  localparam logic [ActionWidth-1:0] ActRead     = 3'd5;

  localparam logic [StatusWidth-1:0] StOk       = 2'd0;
  localparam logic [StatusWidth-1:0] StFull     = 2'd1;
  localparam logic [StatusWidth-1:0] StNotFound = 2'd2;
  localparam logic [StatusWidth-1:0] StEmpty    = 2'd3;
endpackage

FILE: rtl/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine: cell store, free list and walk sequencer.
// Insert at head goes straight to linking the new cell; tail and sorted insert walk the list
// first, and deletes visit cells until the walk ends (a delete first that hits stops there).
// A read gives one word per strobe, last_o on the final word; a full store or an empty
// read answers straight from idle. busy_o is high while a walk runs. The receiver
// cannot stall. Reset (rst_ni low, asynchronous) empties the list and chains every cell
// into the free list; cell values stay undefined until written.
module cursor_linked_list_engine #(
  parameter int unsigned DEPTH = cll_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [cll_pkg::ActionWidth-1:0]   action_i,
  input  logic signed [cll_pkg::ValueWidth-1:0] value_i,
  output logic                              strobe_o,
  output logic [cll_pkg::StatusWidth-1:0]   status_o,
  output logic signed [cll_pkg::ValueWidth-1:0] element_o,
  output logic [cll_pkg::CountWidth-1:0]    removed_count_o,
  output logic                              last_o
);
  // Pointers are wide enough to hold DEPTH itself, which encodes the null link.
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] Nil = PW'(DEPTH);
  localparam int unsigned CW = cll_pkg::CountWidth;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SWalk = 3'd1;
  localparam logic [2:0] SLink = 3'd2;
  localparam logic [2:0] SDel  = 3'd3;
  localparam logic [2:0] SRead = 3'd4;

  // The link array is small and its reset value is known, so it lives in flops.
  // Cell values have no defined reset and sit in a plain array.
  logic [PW-1:0] link_q [DEPTH];
  logic [cll_pkg::ValueWidth-1:0] val_q [DEPTH];

  logic [2:0]  state_q;
  logic [PW-1:0] head_q, free_q, cur_q, prev_q, new_q;
  logic [cll_pkg::ActionWidth-1:0] act_q;
  logic [cll_pkg::ValueWidth-1:0]  v_q;
  logic [PW:0]   steps_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [PW-1:0] norm(input logic [PW-1:0] p);
    norm = (p < Nil) ? p : Nil;
  endfunction

  // One read port: the link and value of the current cursor cell.
  logic [PW-1:0] cur_link;
  logic [cll_pkg::ValueWidth-1:0] cur_val;
  logic cur_nil;
  assign cur_nil  = (cur_q == Nil);
  assign cur_link = cur_nil ? Nil : norm(link_q[cur_q[IW-1:0]]);
  assign cur_val  = cur_nil ? '0 : val_q[cur_q[IW-1:0]];

  // The single shared compare unit: signed less-than and equality on the cursor value.
  logic cmp_lt, cmp_eq, walk_end;
  assign cmp_lt   = $signed(cur_val) < $signed(v_q);
  assign cmp_eq   = (cur_val == v_q);
  assign walk_end = cur_nil || (steps_q >= (PW+1)'(DEPTH));

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      head_q   <= Nil;
      free_q   <= '0;
      for (int i = 0; i < DEPTH; i++) link_q[i] <= PW'(i + 1);
      strobe_o <= 1'b0;
      status_o <= '0;
      element_o <= '0;
      removed_count_o <= '0;
      last_o   <= 1'b0;
      cur_q <= Nil; prev_q <= Nil; new_q <= Nil;
      act_q <= '0; v_q <= '0; steps_q <= '0; cnt_q <= '0;
    end else begin
      strobe_o <= 1'b0;
      element_o <= '0;
      removed_count_o <= '0;
      status_o <= cll_pkg::StOk;
      last_o <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) begin
            act_q   <= action_i;
            v_q     <= value_i;
            cur_q   <= norm(head_q);
            prev_q  <= Nil;
            steps_q <= '0;
            cnt_q   <= '0;
            case (action_i)
              cll_pkg::ActInsHead, cll_pkg::ActInsTail, cll_pkg::ActInsSort: begin
                if (norm(free_q) == Nil) begin
                  strobe_o <= 1'b1;
                  status_o <= cll_pkg::StFull;
                  last_o   <= 1'b1;
                end else begin
                  new_q  <= free_q;
                  val_q[free_q[IW-1:0]] <= value_i;
                  free_q <= norm(link_q[free_q[IW-1:0]]);
                  state_q <= (action_i == cll_pkg::ActInsHead) ? SLink : SWalk;
                end
              end
              cll_pkg::ActDelFirst, cll_pkg::ActDelAll: state_q <= SDel;
              cll_pkg::ActRead: begin
                if (norm(head_q) == Nil) begin
                  strobe_o <= 1'b1;
                  status_o <= cll_pkg::StEmpty;
                  last_o   <= 1'b1;
                end else begin
                  state_q <= SRead;
                end
              end
              default: ;
            endcase
          end
        end
        SWalk: begin
          if (walk_end || (act_q == cll_pkg::ActInsSort && !cmp_lt)) begin
            if (act_q == cll_pkg::ActInsTail) cur_q <= Nil;
            state_q <= SLink;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= cur_link;
            steps_q <= steps_q + 1'b1;
          end
        end
        SLink: begin
          link_q[new_q[IW-1:0]] <= cur_q;
          if (prev_q == Nil) head_q <= new_q;
          else link_q[prev_q[IW-1:0]] <= new_q;
          strobe_o <= 1'b1;
          last_o   <= 1'b1;
          state_q  <= SIdle;
        end
        SDel: begin
          if (walk_end) begin
            strobe_o <= 1'b1;
            last_o   <= 1'b1;
            status_o <= (cnt_q != '0) ? cll_pkg::StOk : cll_pkg::StNotFound;
            removed_count_o <= cnt_q;
            state_q  <= SIdle;
          end else begin
            steps_q <= steps_q + 1'b1;
            if (cmp_eq) begin
              if (prev_q == Nil) head_q <= cur_link;
              else link_q[prev_q[IW-1:0]] <= cur_link;
              link_q[cur_q[IW-1:0]] <= norm(free_q);
              free_q <= cur_q;
              if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
              cur_q <= cur_link;
              if (act_q == cll_pkg::ActDelFirst) begin
                strobe_o <= 1'b1;
                last_o   <= 1'b1;
                removed_count_o <= CW'(1);
                state_q  <= SIdle;
              end
            end else begin
              prev_q <= cur_q;
              cur_q  <= cur_link;
            end
          end
        end
        SRead: begin
          strobe_o  <= 1'b1;
          element_o <= cur_val;
          steps_q   <= steps_q + 1'b1;
          cur_q     <= cur_link;
          if (cur_link == Nil || steps_q == (PW+1)'(DEPTH - 1)) begin
            last_o  <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
